[hw/rtl/cpcb_pkg.sv]
// ----------------------------------------------------------------------------
// cpcb_pkg: shared types and constants for the circle pair collider
// Request and response payloads and fixed arithmetic widths.
// ----------------------------------------------------------------------------
`default_nettype none

package cpcb_pkg;

  // Coordinate and velocity width, signed Q16.16
  localparam int COORD_WIDTH = 32;
  // Radius and mass width, unsigned Q15.16
  localparam int SCALAR_W    = 31;
  // Quotients are clamped to this many bits
  localparam int QUOT_W      = 63;
  localparam logic [QUOT_W-1:0] QUOT_LIMIT = 63'h4000_0000_0000_0000;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_a_x;
    logic signed [COORD_WIDTH-1:0] pos_a_y;
    logic signed [COORD_WIDTH-1:0] vel_a_x;
    logic signed [COORD_WIDTH-1:0] vel_a_y;
    logic signed [COORD_WIDTH-1:0] pos_b_x;
    logic signed [COORD_WIDTH-1:0] pos_b_y;
    logic signed [COORD_WIDTH-1:0] vel_b_x;
    logic signed [COORD_WIDTH-1:0] vel_b_y;
    logic        [SCALAR_W-1:0]    radius_a;
    logic        [SCALAR_W-1:0]    radius_b;
    logic        [SCALAR_W-1:0]    mass_a;
    logic        [SCALAR_W-1:0]    mass_b;
  } req_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] new_vel_a_x;
    logic signed [COORD_WIDTH-1:0] new_vel_a_y;
    logic signed [COORD_WIDTH-1:0] new_vel_b_x;
    logic signed [COORD_WIDTH-1:0] new_vel_b_y;
  } rsp_t;

endpackage

`default_nettype wire

[hw/rtl/circle_pair_collide_and_bounce.sv]
// Request to response through 33- and 32-step roots and 66/95/96-step dividers in series;
// throughput one request per cycle while no response is stalled, set by full pipelining.
// A stalled response freezes every stage; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// circle_pair_collide_and_bounce: swept circle pair test and elastic bounce
// Deep pipeline: squares, roots, closest-approach test, impulse, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_pair_collide_and_bounce
  import cpcb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output      logic req_stall,
  input  wire req_t req,
  output      logic rsp_valid,
  input  wire logic rsp_stall,
  output      rsp_t rsp
);

  localparam int CW     = COORD_WIDTH;
  localparam int DW     = CW + 1;
  localparam int SQW    = 2 * DW;
  localparam int RAD_W  = SCALAR_W + 1;
  localparam int RR_W   = 2 * RAD_W;
  localparam int JN_W   = QUOT_W + RAD_W;
  localparam int DN_W   = QUOT_W + DW;
  localparam int CMP_W  = ((DW > RAD_W) ? DW : RAD_W) + 1;
  localparam int FX_W   = (2 * QUOT_W > SQW) ? 2 * QUOT_W : SQW;
  localparam int FR_W   = (SQW > RR_W) ? SQW : RR_W;
  localparam int EW     = ((CW > QUOT_W) ? CW : QUOT_W) + 2;

  typedef struct packed {
    logic                   rej;
    logic signed [CW-1:0]   vax;
    logic signed [CW-1:0]   vay;
    logic signed [CW-1:0]   vbx;
    logic signed [CW-1:0]   vby;
    logic                   sx;
    logic                   sy;
    logic                   dsx;
    logic                   dsy;
    logic [DW-1:0]          ux;
    logic [DW-1:0]          uy;
    logic [RAD_W-1:0]       r;
    logic [SCALAR_W-1:0]    ma;
    logic [SCALAR_W-1:0]    mb;
    logic [RAD_W-1:0]       msum;
    logic [SQW-1:0]         sqc;
    logic [SQW-1:0]         dot;
    logic [RR_W-1:0]        rr;
    logic [DW-1:0]          magv;
    logic [DW-1:0]          magc;
    logic [QUOT_W-1:0]      dd;
    logic [QUOT_W-1:0]      a;
    logic [JN_W-1:0]        jan;
    logic [JN_W-1:0]        jbn;
    logic [QUOT_W-1:0]      ja;
    logic [QUOT_W-1:0]      jb;
  } ctx_t;

  localparam int CTX_W = $bits(ctx_t);

  // global advance: the whole pipe holds while the response waits
  logic en;
  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  // saturate a wide signed value to CW bits
  function automatic logic [CW-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] smax;
    logic signed [EW-1:0] smin;
    smax = $signed({{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}});
    smin = -smax - EW'(1);
    if (v > smax) begin
      sat = smax[CW-1:0];
    end else if (v < smin) begin
      sat = smin[CW-1:0];
    end else begin
      sat = v[CW-1:0];
    end
  endfunction

  // ---------------------------------------------------------------- stage 0
  // relative vectors, magnitudes, early rejects
  logic signed [DW-1:0] cx0, cy0, vx0, vy0;
  ctx_t                 ctx0_n, s0_ctx;
  logic                 s0_vld;
  logic [DW-1:0]        s0_mvx, s0_mvy;
  logic [DW-1:0]        mvx0, mvy0;

  assign cx0  = DW'(req.pos_b_x) - DW'(req.pos_a_x);
  assign cy0  = DW'(req.pos_b_y) - DW'(req.pos_a_y);
  assign vx0  = DW'(req.vel_a_x) - DW'(req.vel_b_x);
  assign vy0  = DW'(req.vel_a_y) - DW'(req.vel_b_y);
  assign mvx0 = vx0[DW-1] ? DW'(-vx0) : DW'(vx0);
  assign mvy0 = vy0[DW-1] ? DW'(-vy0) : DW'(vy0);

  always_comb begin
    ctx0_n      = '0;
    ctx0_n.vax  = req.vel_a_x;
    ctx0_n.vay  = req.vel_a_y;
    ctx0_n.vbx  = req.vel_b_x;
    ctx0_n.vby  = req.vel_b_y;
    ctx0_n.sx   = cx0[DW-1];
    ctx0_n.sy   = cy0[DW-1];
    ctx0_n.dsx  = vx0[DW-1] ^ cx0[DW-1];
    ctx0_n.dsy  = vy0[DW-1] ^ cy0[DW-1];
    ctx0_n.ux   = cx0[DW-1] ? DW'(-cx0) : DW'(cx0);
    ctx0_n.uy   = cy0[DW-1] ? DW'(-cy0) : DW'(cy0);
    ctx0_n.r    = RAD_W'(req.radius_a) + RAD_W'(req.radius_b);
    ctx0_n.ma   = req.mass_a;
    ctx0_n.mb   = req.mass_b;
    ctx0_n.msum = RAD_W'(req.mass_a) + RAD_W'(req.mass_b);
    ctx0_n.rej  = (vx0 == '0 && vy0 == '0) || (cx0 == '0 && cy0 == '0)
                  || (ctx0_n.msum == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ctx <= ctx0_n;
      s0_mvx <= mvx0;
      s0_mvy <= mvy0;
    end
  end

  // ---------------------------------------------------------------- squares
  logic             p1_vld;
  logic [CTX_W-1:0] p1_sb;
  ctx_t             p1_ctx;
  logic [SQW-1:0]   p1_vx2, p1_vy2, p1_cx2, p1_cy2, p1_xx, p1_yy;
  logic [RR_W-1:0]  p1_rr;

  cpcb_mul #(.A_W(DW), .B_W(DW), .SB_W(CTX_W)) u_mul_vx2 (
    .clk, .rst, .en, .vld_i(s0_vld), .a_i(s0_mvx), .b_i(s0_mvx), .sb_i(s0_ctx),
    .vld_o(p1_vld), .p_o(p1_vx2), .sb_o(p1_sb));
  cpcb_mul #(.A_W(DW), .B_W(DW), .SB_W(1)) u_mul_vy2 (
    .clk, .rst, .en, .vld_i(s0_vld), .a_i(s0_mvy), .b_i(s0_mvy), .sb_i(1'b0),
    .vld_o(), .p_o(p1_vy2), .sb_o());
  cpcb_mul #(.A_W(DW), .B_W(DW), .SB_W(1)) u_mul_cx2 (
    .clk, .rst, .en, .vld_i(s0_vld), .a_i(s0_ctx.ux), .b_i(s0_ctx.ux), .sb_i(1'b0),
    .vld_o(), .p_o(p1_cx2), .sb_o());
  cpcb_mul #(.A_W(DW), .B_W(DW), .SB_W(1)) u_mul_cy2 (
    .clk, .rst, .en, .vld_i(s0_vld), .a_i(s0_ctx.uy), .b_i(s0_ctx.uy), .sb_i(1'b0),
    .vld_o(), .p_o(p1_cy2), .sb_o());
  cpcb_mul #(.A_W(DW), .B_W(DW), .SB_W(1)) u_mul_xx (
    .clk, .rst, .en, .vld_i(s0_vld), .a_i(s0_mvx), .b_i(s0_ctx.ux), .sb_i(1'b0),
    .vld_o(), .p_o(p1_xx), .sb_o());
  cpcb_mul #(.A_W(DW), .B_W(DW), .SB_W(1)) u_mul_yy (
    .clk, .rst, .en, .vld_i(s0_vld), .a_i(s0_mvy), .b_i(s0_ctx.uy), .sb_i(1'b0),
    .vld_o(), .p_o(p1_yy), .sb_o());
  cpcb_mul #(.A_W(RAD_W), .B_W(RAD_W), .SB_W(1)) u_mul_rr (
    .clk, .rst, .en, .vld_i(s0_vld), .a_i(s0_ctx.r), .b_i(s0_ctx.r), .sb_i(1'b0),
    .vld_o(), .p_o(p1_rr), .sb_o());

  assign p1_ctx = ctx_t'(p1_sb);

  // ---------------------------------------------------------------- stage 2
  // squared lengths and signed dot product
  logic           s2_vld;
  ctx_t           ctx2_n, s2_ctx;
  logic [SQW-1:0] s2_sqv;
  logic [SQW-1:0] dpos2, dneg2;

  always_comb begin
    dpos2 = (p1_ctx.dsx ? '0 : p1_xx) + (p1_ctx.dsy ? '0 : p1_yy);
    dneg2 = (p1_ctx.dsx ? p1_xx : '0) + (p1_ctx.dsy ? p1_yy : '0);
    ctx2_n     = p1_ctx;
    ctx2_n.sqc = p1_cx2 + p1_cy2;
    ctx2_n.dot = dpos2 - dneg2;
    ctx2_n.rr  = p1_rr;
    ctx2_n.rej = p1_ctx.rej || !(dpos2 > dneg2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctx <= ctx2_n;
      s2_sqv <= p1_vx2 + p1_vy2;
    end
  end

  // ---------------------------------------------------------------- lengths
  logic             p3_vld;
  logic [CTX_W-1:0] p3_sb;
  ctx_t             p3_ctx;
  logic [DW-1:0]    p3_magv, p3_magc;

  cpcb_sqrt #(.IN_W(SQW), .SB_W(CTX_W)) u_sqrt_v (
    .clk, .rst, .en, .vld_i(s2_vld), .rad_i(s2_sqv), .sb_i(s2_ctx),
    .vld_o(p3_vld), .root_o(p3_magv), .sb_o(p3_sb));
  cpcb_sqrt #(.IN_W(SQW), .SB_W(1)) u_sqrt_c (
    .clk, .rst, .en, .vld_i(s2_vld), .rad_i(s2_ctx.sqc), .sb_i(1'b0),
    .vld_o(), .root_o(p3_magc), .sb_o());

  assign p3_ctx = ctx_t'(p3_sb);

  // ---------------------------------------------------------------- stage 4
  // reject when the travel cannot close the gap
  logic s4_vld;
  ctx_t ctx4_n, s4_ctx;

  always_comb begin
    ctx4_n      = p3_ctx;
    ctx4_n.magv = p3_magv;
    ctx4_n.magc = p3_magc;
    ctx4_n.rej  = p3_ctx.rej
                  || ((CMP_W'(p3_magv) + CMP_W'(p3_ctx.r)) < CMP_W'(p3_magc));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= p3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ctx <= ctx4_n;
    end
  end

  // ---------------------------------------------------------------- projections
  logic              p5_vld;
  logic [CTX_W-1:0]  p5_sb;
  ctx_t              p5_ctx;
  logic [QUOT_W-1:0] p5_dd, p5_a;

  cpcb_div #(.N_W(SQW), .D_W(DW), .SB_W(CTX_W)) u_div_dd (
    .clk, .rst, .en, .vld_i(s4_vld), .num_i(s4_ctx.dot), .den_i(s4_ctx.magv),
    .sb_i(s4_ctx), .vld_o(p5_vld), .quo_o(p5_dd), .sb_o(p5_sb));
  cpcb_div #(.N_W(SQW), .D_W(DW), .SB_W(1)) u_div_a (
    .clk, .rst, .en, .vld_i(s4_vld), .num_i(s4_ctx.dot), .den_i(s4_ctx.magc),
    .sb_i(1'b0), .vld_o(), .quo_o(p5_a), .sb_o());

  assign p5_ctx = ctx_t'(p5_sb);

  // ---------------------------------------------------------------- stage 6
  logic s6_vld;
  ctx_t ctx6_n, s6_ctx;

  always_comb begin
    ctx6_n    = p5_ctx;
    ctx6_n.dd = p5_dd;
    ctx6_n.a  = p5_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (en) begin
      s6_vld <= p5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_ctx <= ctx6_n;
    end
  end

  // ---------------------------------------------------------------- D^2, impulse numerators
  logic                p7_vld;
  logic [CTX_W-1:0]    p7_sb;
  ctx_t                p7_ctx;
  logic [2*QUOT_W-1:0] p7_d2;
  logic [JN_W-1:0]     p7_jan, p7_jbn;

  cpcb_mul #(.A_W(QUOT_W), .B_W(QUOT_W), .SB_W(CTX_W)) u_mul_d2 (
    .clk, .rst, .en, .vld_i(s6_vld), .a_i(s6_ctx.dd), .b_i(s6_ctx.dd),
    .sb_i(s6_ctx), .vld_o(p7_vld), .p_o(p7_d2), .sb_o(p7_sb));
  cpcb_mul #(.A_W(QUOT_W), .B_W(RAD_W), .SB_W(1)) u_mul_jan (
    .clk, .rst, .en, .vld_i(s6_vld), .a_i(s6_ctx.a), .b_i({s6_ctx.mb, 1'b0}),
    .sb_i(1'b0), .vld_o(), .p_o(p7_jan), .sb_o());
  cpcb_mul #(.A_W(QUOT_W), .B_W(RAD_W), .SB_W(1)) u_mul_jbn (
    .clk, .rst, .en, .vld_i(s6_vld), .a_i(s6_ctx.a), .b_i({s6_ctx.ma, 1'b0}),
    .sb_i(1'b0), .vld_o(), .p_o(p7_jbn), .sb_o());

  assign p7_ctx = ctx_t'(p7_sb);

  // ---------------------------------------------------------------- stage 8
  // closest approach: F = max(0, |C|^2 - D^2), reject when F >= r^2
  logic            s8_vld;
  ctx_t            ctx8_n, s8_ctx;
  logic [RR_W-1:0] s8_rad;
  logic [FX_W-1:0] sqc8_x, d2_8_x;
  logic [SQW-1:0]  f8;
  logic [FR_W-1:0] rad8;

  always_comb begin
    sqc8_x     = FX_W'(p7_ctx.sqc);
    d2_8_x     = FX_W'(p7_d2);
    f8         = (sqc8_x > d2_8_x) ? SQW'(sqc8_x - d2_8_x) : '0;
    rad8       = FR_W'(p7_ctx.rr) - FR_W'(f8);
    ctx8_n     = p7_ctx;
    ctx8_n.jan = p7_jan;
    ctx8_n.jbn = p7_jbn;
    ctx8_n.rej = p7_ctx.rej || (FR_W'(f8) >= FR_W'(p7_ctx.rr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else if (en) begin
      s8_vld <= p7_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_ctx <= ctx8_n;
      s8_rad <= rad8[RR_W-1:0];
    end
  end

  // ---------------------------------------------------------------- contact depth
  logic             p9_vld;
  logic [CTX_W-1:0] p9_sb;
  ctx_t             p9_ctx;
  logic [RAD_W-1:0] p9_root;

  cpcb_sqrt #(.IN_W(RR_W), .SB_W(CTX_W)) u_sqrt_t (
    .clk, .rst, .en, .vld_i(s8_vld), .rad_i(s8_rad), .sb_i(s8_ctx),
    .vld_o(p9_vld), .root_o(p9_root), .sb_o(p9_sb));

  assign p9_ctx = ctx_t'(p9_sb);

  // ---------------------------------------------------------------- stage 10
  // reject when contact lies beyond this step's travel
  logic s10_vld;
  ctx_t ctx10_n, s10_ctx;

  always_comb begin
    ctx10_n     = p9_ctx;
    ctx10_n.rej = p9_ctx.rej
                  || (((QUOT_W+1)'(p9_ctx.magv) + (QUOT_W+1)'(p9_root))
                      < (QUOT_W+1)'(p9_ctx.dd));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_vld <= 1'b0;
    end else if (en) begin
      s10_vld <= p9_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_ctx <= ctx10_n;
    end
  end

  // ---------------------------------------------------------------- mass split
  logic              p11_vld;
  logic [CTX_W-1:0]  p11_sb;
  ctx_t              p11_ctx;
  logic [QUOT_W-1:0] p11_ja, p11_jb;

  cpcb_div #(.N_W(JN_W), .D_W(RAD_W), .SB_W(CTX_W)) u_div_ja (
    .clk, .rst, .en, .vld_i(s10_vld), .num_i(s10_ctx.jan), .den_i(s10_ctx.msum),
    .sb_i(s10_ctx), .vld_o(p11_vld), .quo_o(p11_ja), .sb_o(p11_sb));
  cpcb_div #(.N_W(JN_W), .D_W(RAD_W), .SB_W(1)) u_div_jb (
    .clk, .rst, .en, .vld_i(s10_vld), .num_i(s10_ctx.jbn), .den_i(s10_ctx.msum),
    .sb_i(1'b0), .vld_o(), .quo_o(p11_jb), .sb_o());

  assign p11_ctx = ctx_t'(p11_sb);

  // ---------------------------------------------------------------- stage 12
  logic s12_vld;
  ctx_t ctx12_n, s12_ctx;

  always_comb begin
    ctx12_n    = p11_ctx;
    ctx12_n.ja = p11_ja;
    ctx12_n.jb = p11_jb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_vld <= 1'b0;
    end else if (en) begin
      s12_vld <= p11_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s12_ctx <= ctx12_n;
    end
  end

  // ---------------------------------------------------------------- impulse per axis
  logic             p13_vld;
  logic [CTX_W-1:0] p13_sb;
  ctx_t             p13_ctx;
  logic [DN_W-1:0]  p13_ax, p13_ay, p13_bx, p13_by;

  cpcb_mul #(.A_W(QUOT_W), .B_W(DW), .SB_W(CTX_W)) u_mul_ax (
    .clk, .rst, .en, .vld_i(s12_vld), .a_i(s12_ctx.ja), .b_i(s12_ctx.ux),
    .sb_i(s12_ctx), .vld_o(p13_vld), .p_o(p13_ax), .sb_o(p13_sb));
  cpcb_mul #(.A_W(QUOT_W), .B_W(DW), .SB_W(1)) u_mul_ay (
    .clk, .rst, .en, .vld_i(s12_vld), .a_i(s12_ctx.ja), .b_i(s12_ctx.uy),
    .sb_i(1'b0), .vld_o(), .p_o(p13_ay), .sb_o());
  cpcb_mul #(.A_W(QUOT_W), .B_W(DW), .SB_W(1)) u_mul_bx (
    .clk, .rst, .en, .vld_i(s12_vld), .a_i(s12_ctx.jb), .b_i(s12_ctx.ux),
    .sb_i(1'b0), .vld_o(), .p_o(p13_bx), .sb_o());
  cpcb_mul #(.A_W(QUOT_W), .B_W(DW), .SB_W(1)) u_mul_by (
    .clk, .rst, .en, .vld_i(s12_vld), .a_i(s12_ctx.jb), .b_i(s12_ctx.uy),
    .sb_i(1'b0), .vld_o(), .p_o(p13_by), .sb_o());

  assign p13_ctx = ctx_t'(p13_sb);

  // ---------------------------------------------------------------- normalize by |C|
  logic              p15_vld;
  logic [CTX_W-1:0]  p15_sb;
  ctx_t              p15_ctx;
  logic [QUOT_W-1:0] p15_ax, p15_ay, p15_bx, p15_by;

  cpcb_div #(.N_W(DN_W), .D_W(DW), .SB_W(CTX_W)) u_div_ax (
    .clk, .rst, .en, .vld_i(p13_vld), .num_i(p13_ax), .den_i(p13_ctx.magc),
    .sb_i(p13_sb), .vld_o(p15_vld), .quo_o(p15_ax), .sb_o(p15_sb));
  cpcb_div #(.N_W(DN_W), .D_W(DW), .SB_W(1)) u_div_ay (
    .clk, .rst, .en, .vld_i(p13_vld), .num_i(p13_ay), .den_i(p13_ctx.magc),
    .sb_i(1'b0), .vld_o(), .quo_o(p15_ay), .sb_o());
  cpcb_div #(.N_W(DN_W), .D_W(DW), .SB_W(1)) u_div_bx (
    .clk, .rst, .en, .vld_i(p13_vld), .num_i(p13_bx), .den_i(p13_ctx.magc),
    .sb_i(1'b0), .vld_o(), .quo_o(p15_bx), .sb_o());
  cpcb_div #(.N_W(DN_W), .D_W(DW), .SB_W(1)) u_div_by (
    .clk, .rst, .en, .vld_i(p13_vld), .num_i(p13_by), .den_i(p13_ctx.magc),
    .sb_i(1'b0), .vld_o(), .quo_o(p15_by), .sb_o());

  assign p15_ctx = ctx_t'(p15_sb);

  // ---------------------------------------------------------------- output
  // signed update, saturation, pass-through on a miss
  logic signed [EW-1:0] dax, day, dbx, dby;
  logic signed [EW-1:0] nax, nay, nbx, nby;
  rsp_t                 rsp_n;

  always_comb begin
    dax = p15_ctx.sx ? -$signed(EW'(p15_ax)) : $signed(EW'(p15_ax));
    day = p15_ctx.sy ? -$signed(EW'(p15_ay)) : $signed(EW'(p15_ay));
    dbx = p15_ctx.sx ? -$signed(EW'(p15_bx)) : $signed(EW'(p15_bx));
    dby = p15_ctx.sy ? -$signed(EW'(p15_by)) : $signed(EW'(p15_by));
    nax = EW'(p15_ctx.vax) - dax;
    nay = EW'(p15_ctx.vay) - day;
    nbx = EW'(p15_ctx.vbx) + dbx;
    nby = EW'(p15_ctx.vby) + dby;
    if (p15_ctx.rej) begin
      rsp_n.hit         = 1'b0;
      rsp_n.new_vel_a_x = p15_ctx.vax;
      rsp_n.new_vel_a_y = p15_ctx.vay;
      rsp_n.new_vel_b_x = p15_ctx.vbx;
      rsp_n.new_vel_b_y = p15_ctx.vby;
    end else begin
      rsp_n.hit         = 1'b1;
      rsp_n.new_vel_a_x = sat(nax);
      rsp_n.new_vel_a_y = sat(nay);
      rsp_n.new_vel_b_x = sat(nbx);
      rsp_n.new_vel_b_y = sat(nby);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= p15_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_n;
    end
  end

  // ---------------------------------------------------------------- checks
  // no response straight out of reset
  a_rst_quiet: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  // an accepted request lands in the first stage
  a_req_enters: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> s0_vld)
    else $error("accepted request lost at pipe entry");

  // a held response freezes the pipe
  a_pipe_frozen: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> ($stable(s0_vld) && $stable(s10_vld)))
    else $error("pipe moved while response stalled");

endmodule

`default_nettype wire

[hw/rtl/cpcb_mul.sv]
// ----------------------------------------------------------------------------
// cpcb_mul: two-stage pipelined unsigned multiplier
// Four half-width partial products in stage one, their sum in stage two.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcb_mul
  import cpcb_pkg::*;
#(
  parameter int A_W  = 32,
  parameter int B_W  = 32,
  parameter int SB_W = 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               vld_i,
  input  wire logic [A_W-1:0]     a_i,
  input  wire logic [B_W-1:0]     b_i,
  input  wire logic [SB_W-1:0]    sb_i,
  output      logic               vld_o,
  output      logic [A_W+B_W-1:0] p_o,
  output      logic [SB_W-1:0]    sb_o
);

  localparam int AL  = A_W / 2;
  localparam int AH  = A_W - AL;
  localparam int BL  = B_W / 2;
  localparam int BH  = B_W - BL;
  localparam int P_W = A_W + B_W;

  logic [AL+BL-1:0] ll_a, ll_b, pll;
  logic [AL+BH-1:0] lh_a, lh_b, plh;
  logic [AH+BL-1:0] hl_a, hl_b, phl;
  logic [AH+BH-1:0] hh_a, hh_b, phh;
  logic             vld1;
  logic [SB_W-1:0]  sb1;

  // operand halves, zero extended to product width
  assign ll_a = (AL+BL)'(a_i[AL-1:0]);
  assign ll_b = (AL+BL)'(b_i[BL-1:0]);
  assign lh_a = (AL+BH)'(a_i[AL-1:0]);
  assign lh_b = (AL+BH)'(b_i[B_W-1:BL]);
  assign hl_a = (AH+BL)'(a_i[A_W-1:AL]);
  assign hl_b = (AH+BL)'(b_i[BL-1:0]);
  assign hh_a = (AH+BH)'(a_i[A_W-1:AL]);
  assign hh_b = (AH+BH)'(b_i[B_W-1:BL]);

  // stage one: partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pll <= ll_a * ll_b;
      plh <= lh_a * lh_b;
      phl <= hl_a * hl_b;
      phh <= hh_a * hh_b;
      sb1 <= sb_i;
    end
  end

  // stage two: aligned sum
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_o  <= (P_W'(phh) << (AL + BL)) + (P_W'(phl) << AL) + (P_W'(plh) << BL)
              + P_W'(pll);
      sb_o <= sb1;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cpcb_sqrt.sv]
// ----------------------------------------------------------------------------
// cpcb_sqrt: pipelined integer square root
// Floor root, one result bit per stage, restoring digit by digit.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcb_sqrt
  import cpcb_pkg::*;
#(
  parameter int IN_W = 64,
  parameter int SB_W = 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                vld_i,
  input  wire logic [IN_W-1:0]     rad_i,
  input  wire logic [SB_W-1:0]     sb_i,
  output      logic                vld_o,
  output      logic [IN_W/2-1:0]   root_o,
  output      logic [SB_W-1:0]     sb_o
);

  localparam int OUT_W = IN_W / 2;
  localparam int RM_W  = OUT_W + 2;

  logic              vld_q  [OUT_W];
  logic [IN_W-1:0]   rad_q  [OUT_W];
  logic [RM_W-1:0]   rem_q  [OUT_W];
  logic [OUT_W-1:0]  root_q [OUT_W];
  logic [SB_W-1:0]   sb_q   [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic              vld_p;
    logic [IN_W-1:0]   rad_p;
    logic [RM_W-1:0]   rem_p;
    logic [OUT_W-1:0]  root_p;
    logic [SB_W-1:0]   sb_p;
    logic [RM_W+1:0]   shifted;
    logic [RM_W+1:0]   trial;
    logic              take;

    if (k == 0) begin : g_first
      assign vld_p  = vld_i;
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign sb_p   = sb_i;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign sb_p   = sb_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign shifted = {rem_p, rad_p[IN_W-1-2*k -: 2]};
    assign trial   = (RM_W+2)'({root_p, 2'b01});
    assign take    = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k]  <= rad_p;
        rem_q[k]  <= take ? RM_W'(shifted - trial) : RM_W'(shifted);
        root_q[k] <= {root_p[OUT_W-2:0], take};
        sb_q[k]   <= sb_p;
      end
    end
  end

  assign vld_o  = vld_q[OUT_W-1];
  assign root_o = root_q[OUT_W-1];
  assign sb_o   = sb_q[OUT_W-1];

endmodule

`default_nettype wire

[hw/rtl/cpcb_div.sv]
// ----------------------------------------------------------------------------
// cpcb_div: pipelined unsigned restoring divider
// One quotient bit per stage; the quotient is clamped to QUOT_LIMIT.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcb_div
  import cpcb_pkg::*;
#(
  parameter int N_W  = 64,
  parameter int D_W  = 32,
  parameter int SB_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic [N_W-1:0]    num_i,
  input  wire logic [D_W-1:0]    den_i,
  input  wire logic [SB_W-1:0]   sb_i,
  output      logic              vld_o,
  output      logic [QUOT_W-1:0] quo_o,
  output      logic [SB_W-1:0]   sb_o
);

  localparam int EXT_W = (N_W > QUOT_W) ? N_W : QUOT_W;

  logic             vld_q [N_W];
  logic [N_W-1:0]   num_q [N_W];
  logic [D_W-1:0]   den_q [N_W];
  logic [D_W-1:0]   rem_q [N_W];
  logic [N_W-1:0]   quo_q [N_W];
  logic [SB_W-1:0]  sb_q  [N_W];

  for (genvar k = 0; k < N_W; k++) begin : g_stage
    logic             vld_p;
    logic [N_W-1:0]   num_p;
    logic [D_W-1:0]   den_p;
    logic [D_W-1:0]   rem_p;
    logic [N_W-1:0]   quo_p;
    logic [SB_W-1:0]  sb_p;
    logic [D_W:0]     trial;
    logic             take;
    logic [N_W-1:0]   quo_n;

    if (k == 0) begin : g_first
      assign vld_p = vld_i;
      assign num_p = num_i;
      assign den_p = den_i;
      assign rem_p = '0;
      assign quo_p = '0;
      assign sb_p  = sb_i;
    end else begin : g_next
      assign vld_p = vld_q[k-1];
      assign num_p = num_q[k-1];
      assign den_p = den_q[k-1];
      assign rem_p = rem_q[k-1];
      assign quo_p = quo_q[k-1];
      assign sb_p  = sb_q[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign trial = {rem_p, num_p[N_W-1-k]};
    assign take  = trial >= {1'b0, den_p};

    always_comb begin
      quo_n             = quo_p;
      quo_n[N_W-1-k]    = take;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_q[k] <= num_p;
        den_q[k] <= den_p;
        rem_q[k] <= take ? D_W'(trial - {1'b0, den_p}) : D_W'(trial);
        quo_q[k] <= quo_n;
        sb_q[k]  <= sb_p;
      end
    end
  end

  // clamp
  logic [EXT_W-1:0] quo_x;
  assign quo_x = EXT_W'(quo_q[N_W-1]);
  assign quo_o = (quo_x > EXT_W'(QUOT_LIMIT)) ? QUOT_LIMIT : quo_x[QUOT_W-1:0];
  assign vld_o = vld_q[N_W-1];
  assign sb_o  = sb_q[N_W-1];

endmodule

`default_nettype wire
